@@ sv/stretched_allpass_cascade_top_macros.svh @@
// ----------------------------------------------------------------------------
// Stretched allpass cascade assertion macros
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STRETCHED_ALLPASS_CASCADE_TOP_MACROS_SVH
`define STRETCHED_ALLPASS_CASCADE_TOP_MACROS_SVH

// same-cycle implication
`define SAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sac_pkg.sv @@
// ----------------------------------------------------------------------------
// sac_pkg
// Types and constants shared by the stretched allpass cascade modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

	localparam int COEF_BITS = 24;
	localparam int COEF_FRAC = 22;
	localparam int OUTER_BITS = 22;
	localparam int STRETCH_BITS = 4;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [1:0] REG_OUTER   = 2'd0;
	localparam logic [1:0] REG_INNER   = 2'd1;
	localparam logic [1:0] REG_STRETCH = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_P5,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_M1,
		OP_M2,
		OP_M3,
		OP_M4,
		OP_M5
	} dp_op_t;

	typedef struct packed {
		logic   clr;
		logic   start;
		logic   issue;
		dp_op_t op;
		logic   finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic last_stage;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic [OUTER_BITS-1:0]   outer;
		logic [COEF_BITS-1:0]    inner;
		logic [STRETCH_BITS-1:0] stretch;
	} cfg_t;

endpackage

`default_nettype wire

@@ sv/sac_ram.sv @@
// ----------------------------------------------------------------------------
// sac_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ sv/sac_ctrl.sv @@
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer: clearing pass, item accept, five phases per stage, output load.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  sac_pkg::status_t status,
	output logic             in_ready,
	output sac_pkg::cmd_t    cmd
);

	import sac_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nx = ST_READ;
			end
			ST_READ:  state_nx = ST_P1;
			ST_P1:    state_nx = ST_P2;
			ST_P2:    state_nx = ST_P3;
			ST_P3:    state_nx = ST_P4;
			ST_P4:    state_nx = ST_P5;
			ST_P5: begin
				state_nx = status.last_stage ? ST_FINISH : ST_P1;
			end
			ST_FINISH: begin
				if (status.out_free) state_nx = ST_IDLE;
			end
			default:  state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.clr    = 1'b0;
		cmd.start  = 1'b0;
		cmd.issue  = 1'b0;
		cmd.op     = OP_NONE;
		cmd.finish = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_READ:  cmd.issue = 1'b1;
			ST_P1:    cmd.op = OP_M1;
			ST_P2:    cmd.op = OP_M2;
			ST_P3:    cmd.op = OP_M3;
			ST_P4:    cmd.op = OP_M4;
			ST_P5: begin
				cmd.op    = OP_M5;
				cmd.issue = !status.last_stage;
			end
			ST_FINISH: cmd.finish = status.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/sac_dp.sv @@
// ----------------------------------------------------------------------------
// sac_dp
// Datapath: shared coefficient multiplier, stage rings and inner memories,
// write index, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_dp #(
	parameter int STAGES      = 80,
	parameter int RING_DEPTH  = 16,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sac_pkg::cfg_t                 cfg,
	input  sac_pkg::cmd_t                 cmd,
	output sac_pkg::status_t              status,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	import sac_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int RB  = $clog2(RING_DEPTH);
	localparam int DD  = STAGES * RING_DEPTH;
	localparam int DAW = $clog2(DD);
	localparam int SGW = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int PW  = COEF_BITS + SB;
	localparam int RW  = SB + 3;
	localparam int EW  = SB + 4;

	localparam logic signed [EW-1:0] SMAX = {5'b00000, {(SB-1){1'b1}}};
	localparam logic signed [EW-1:0] SMIN = {5'b11111, {(SB-1){1'b0}}};
	localparam logic signed [PW:0] RND_BIAS =
		{{(PW+1-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

	function automatic logic signed [SB-1:0] sat(input logic signed [EW-1:0] v);
		logic signed [SB-1:0] r;
		if (v > SMAX) begin
			r = SMAX[SB-1:0];
		end else if (v < SMIN) begin
			r = SMIN[SB-1:0];
		end else begin
			r = v[SB-1:0];
		end
		return r;
	endfunction

	logic [RB-1:0]  wr_q;
	logic [RB-1:0]  rd_q;
	logic [RB-1:0]  back_v;
	logic [RB:0]    rd_sum;
	logic [RB:0]    rd_v;
	logic [DAW-1:0] base_q;
	logic [DAW-1:0] base_nx;
	logic [DAW-1:0] clr_q;
	logic [SGW-1:0] stage_q;

	logic signed [SB-1:0] x_q;
	logic signed [SB-1:0] s1_q;
	logic signed [SB-1:0] s2_q;
	logic signed [PW-1:0] prod_q;
	logic                 out_valid_q;
	logic signed [SB-1:0] sample_out_q;

	logic signed [COEF_BITS-1:0] a1;
	logic signed [COEF_BITS-1:0] a2;
	logic signed [COEF_BITS-1:0] mul_a;
	logic signed [SB-1:0]        mul_b;
	logic signed [PW-1:0]        mul_a_ext;
	logic signed [PW-1:0]        mul_b_ext;
	logic signed [PW-1:0]        prod_d;
	logic signed [PW:0]          rsum;
	logic signed [RW-1:0]        rnd_v;
	logic signed [EW-1:0]        rnd_ext;
	logic signed [EW-1:0]        x_ext;
	logic signed [EW-1:0]        s1_ext;
	logic signed [EW-1:0]        m_ext;
	logic signed [EW-1:0]        p_ext;
	logic signed [EW-1:0]        s1_sum;
	logic signed [EW-1:0]        s2_sum;
	logic signed [EW-1:0]        x_sum;
	logic signed [EW-1:0]        w_sum;
	logic signed [SB-1:0]        m;
	logic signed [SB-1:0]        p;

	logic           d_we;
	logic [DAW-1:0] d_waddr;
	logic [SB-1:0]  d_wdata;
	logic [DAW-1:0] d_raddr;
	logic [SB-1:0]  d_rdata;
	logic           i_we;
	logic [SGW-1:0] i_waddr;
	logic [SB-1:0]  i_wdata;
	logic [SGW-1:0] i_raddr;
	logic [SB-1:0]  i_rdata;
	logic           adv;

	// stretch modulo ring depth, then read position behind the write index
	always_comb begin
		logic [3:0]    v;
		logic [RB+3:0] ext;
		v = cfg.stretch;
		for (int i = 0; i < 8; i++) begin
			if ({3'b000, v} >= 7'(RING_DEPTH)) v = v - 4'(RING_DEPTH);
		end
		ext    = {{RB{1'b0}}, v};
		back_v = ext[RB-1:0];
		rd_sum = {1'b0, wr_q} + (RB+1)'(RING_DEPTH) - {1'b0, back_v};
		rd_v   = (rd_sum >= (RB+1)'(RING_DEPTH)) ? rd_sum - (RB+1)'(RING_DEPTH) : rd_sum;
	end

	assign a1 = $signed({2'b00, cfg.outer});
	assign a2 = $signed(cfg.inner);
	assign m  = $signed(d_rdata);
	assign p  = $signed(i_rdata);

	always_comb begin
		case (cmd.op)
			OP_M2: begin
				mul_a = a2;
				mul_b = p;
			end
			OP_M3: begin
				mul_a = a1;
				mul_b = s1_q;
			end
			OP_M4: begin
				mul_a = a2;
				mul_b = s2_q;
			end
			default: begin
				mul_a = a1;
				mul_b = m;
			end
		endcase
	end

	assign mul_a_ext = PW'(mul_a);
	assign mul_b_ext = PW'(mul_b);
	assign prod_d    = mul_a_ext * mul_b_ext;

	// round half up to the sample format
	assign rsum    = $signed({prod_q[PW-1], prod_q}) + RND_BIAS;
	assign rnd_v   = rsum[PW:COEF_FRAC];
	assign rnd_ext = $signed({rnd_v[RW-1], rnd_v});
	assign x_ext   = $signed({{4{x_q[SB-1]}}, x_q});
	assign s1_ext  = $signed({{4{s1_q[SB-1]}}, s1_q});
	assign m_ext   = $signed({{4{m[SB-1]}}, m});
	assign p_ext   = $signed({{4{p[SB-1]}}, p});
	assign s1_sum  = x_ext - rnd_ext;
	assign s2_sum  = s1_ext - rnd_ext;
	assign x_sum   = rnd_ext + m_ext;
	assign w_sum   = rnd_ext + p_ext;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_M1 || cmd.op == OP_M2 || cmd.op == OP_M3 || cmd.op == OP_M4) begin
			prod_q <= prod_d;
		end
		if (cmd.start) begin
			x_q <= sample_in;
		end else if (cmd.op == OP_M4) begin
			x_q <= sat(x_sum);
		end
		if (cmd.op == OP_M2) s1_q <= sat(s1_sum);
		if (cmd.op == OP_M3) s2_q <= sat(s2_sum);
		if (cmd.finish) sample_out_q <= x_q;
	end

	assign base_nx = base_q + DAW'(RING_DEPTH);
	assign adv     = cmd.issue && (cmd.op == OP_M5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			base_q      <= '0;
			stage_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + DAW'(1);
			if (cmd.start) begin
				rd_q    <= rd_v[RB-1:0];
				base_q  <= '0;
				stage_q <= '0;
			end else if (adv) begin
				base_q  <= base_nx;
				stage_q <= stage_q + SGW'(1);
			end
			if (cmd.finish) begin
				wr_q <= (wr_q == RB'(RING_DEPTH - 1)) ? '0 : wr_q + RB'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign d_we    = cmd.clr || (cmd.op == OP_M5);
	assign d_waddr = cmd.clr ? clr_q : base_q + DAW'(wr_q);
	assign d_wdata = cmd.clr ? '0 : sat(w_sum);
	assign d_raddr = (adv ? base_nx : base_q) + DAW'(rd_q);

	assign i_we    = (cmd.clr && (clr_q < DAW'(STAGES))) || (cmd.op == OP_M4);
	assign i_waddr = cmd.clr ? clr_q[SGW-1:0] : stage_q;
	assign i_wdata = cmd.clr ? '0 : s2_q;
	assign i_raddr = adv ? stage_q + SGW'(1) : stage_q;

	sac_ram #(
		.WIDTH (SB),
		.DEPTH (DD)
	) u_delay_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (cmd.issue),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	sac_ram #(
		.WIDTH (SB),
		.DEPTH (STAGES)
	) u_inner_ram (
		.clk   (clk),
		.we    (i_we),
		.waddr (i_waddr),
		.wdata (i_wdata),
		.re    (cmd.issue),
		.raddr (i_raddr),
		.rdata (i_rdata)
	);

	assign status.clr_last   = (clr_q == DAW'(DD - 1));
	assign status.last_stage = (stage_q == SGW'(STAGES - 1));
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

`default_nettype wire

@@ sv/stretched_allpass_cascade_top.sv @@
// ----------------------------------------------------------------------------
// stretched_allpass_cascade_top
// One spring's chirp cascade of stretched allpass stages, fixed point,
// with APB configuration registers.
//
// channel   signals                          transfer when
// input     in_valid, in_ready, sample_in    in_valid & in_ready
// output    out_valid, out_ready, sample_out out_valid & out_ready
// config    psel, penable, pwrite, paddr,    psel & penable & pwrite
//           pwdata, prdata, pready
//
// After accept an item passes a read step and the phases of each stage, paced by
// the one shared multiplier doing four products per stage plus the ring write;
// no new item is taken until its result is loaded into the output register.
// After reset a clearing pass zeroes the rings and inner memories; no input is
// taken meanwhile. A finished result waits in the output register; a new item
// is taken then, and stalls at its own end if that one is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stretched_allpass_cascade_top_macros.svh"

module stretched_allpass_cascade_top #(
	parameter int STAGES      = 80,
	parameter int RING_DEPTH  = 16,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_BITS-1:0]         sample_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_BITS-1:0]         sample_out,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [sac_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [sac_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [sac_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                  pready
);

	import sac_pkg::*;

	logic [OUTER_BITS-1:0]   outer_q;
	logic [COEF_BITS-1:0]    inner_q;
	logic [STRETCH_BITS-1:0] stretch_q;
	logic                    wr_en;
	logic [1:0]              reg_idx;
	cfg_t                    cfg_w;
	cmd_t                    cmd_w;
	status_t                 status_w;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q   <= '0;
			inner_q   <= '0;
			stretch_q <= STRETCH_BITS'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_OUTER:   outer_q   <= pwdata[OUTER_BITS-1:0];
				REG_INNER:   inner_q   <= pwdata[COEF_BITS-1:0];
				REG_STRETCH: stretch_q <= pwdata[STRETCH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OUTER:   prdata = APB_DATA_BITS'(outer_q);
			REG_INNER:   prdata = {{(APB_DATA_BITS-COEF_BITS){inner_q[COEF_BITS-1]}}, inner_q};
			REG_STRETCH: prdata = APB_DATA_BITS'(stretch_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg_w.outer   = outer_q;
	assign cfg_w.inner   = inner_q;
	assign cfg_w.stretch = stretch_q;

	sac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status_w),
		.in_ready (in_ready),
		.cmd      (cmd_w)
	);

	sac_dp #(
		.STAGES      (STAGES),
		.RING_DEPTH  (RING_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_w),
		.cmd        (cmd_w),
		.status     (status_w),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	`SAC_ASSERT_NOW(a_finish_free, cmd_w.finish, status_w.out_free, "output loaded while occupied")
	`SAC_ASSERT_NEXT(a_finish_valid, cmd_w.finish, out_valid, "finished item not presented")
	`SAC_ASSERT_NOW(a_clear_blocks, cmd_w.clr, !in_ready, "input ready during clearing pass")
	`SAC_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready held after accept")

endmodule

`default_nettype wire
